// ===== hw/rtl/peer_presence_table_unit_defines.svh =====
// assertion macros for the peer presence table
// both forms sample on clk and are disabled while rst_n is low
`ifndef PEER_PRESENCE_TABLE_UNIT_DEFINES_SVH
`define PEER_PRESENCE_TABLE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define PPT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("peer presence table check failed");
`define PPT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("peer presence table check failed");
`else
`define PPT_ASSERT_SAME(lbl, ante, cons)
`define PPT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hw/rtl/ppt_pkg.sv =====
`default_nettype none
package ppt_pkg;

  localparam int TABLE_SLOTS_DEF = 4;

  localparam int ADDR_W   = 48;
  localparam int TIME_W   = 48;
  localparam int POS_W    = 8;
  localparam int WIN_W    = 26;
  localparam int SLOT_W   = 2;
  localparam int ONLINE_W = 3;

  // sized for the largest table (16 entries)
  localparam int SLOT_IDX_W = 4;
  localparam int CNT_W      = 5;

  localparam logic [WIN_W-1:0]    WINDOW_RESET = WIN_W'(2000000);
  localparam logic [ONLINE_W-1:0] ONLINE_MAX   = '1;

  localparam logic OPC_QUERY  = 1'b0;
  localparam logic OPC_REPORT = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE
  } ppt_state_t;

  // partial search result passed from cell to cell
  typedef struct packed {
    logic                  hit_found;
    logic [SLOT_IDX_W-1:0] hit_idx;
    logic                  hit_online;
    logic                  free_found;
    logic [SLOT_IDX_W-1:0] vacant_idx;
    logic [SLOT_IDX_W-1:0] oldest_idx;
    logic [TIME_W-1:0]     oldest_time;
    logic                  oldest_online;
    logic [CNT_W-1:0]      count;
  } ppt_tok_t;

  // entry write broadcast from the sequencer
  typedef struct packed {
    logic                  en;
    logic [SLOT_IDX_W-1:0] idx;
    logic [POS_W-1:0]      pos;
  } ppt_wr_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ppt_cell.sv =====
`default_nettype none
module ppt_cell #(
  parameter int IDX = 0
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       adv,
  input  wire ppt_pkg::ppt_wr_t           wr,
  input  wire logic [ppt_pkg::ADDR_W-1:0] item_addr,
  input  wire logic [ppt_pkg::TIME_W-1:0] item_now,
  input  wire logic [ppt_pkg::WIN_W-1:0]  window,
  input  wire ppt_pkg::ppt_tok_t          tin,
  output ppt_pkg::ppt_tok_t               tout
);
  import ppt_pkg::*;

  localparam logic [SLOT_IDX_W-1:0] MY_IDX = SLOT_IDX_W'(IDX);

  logic              valid_r;
  logic [ADDR_W-1:0] addr_r;
  logic [POS_W-1:0]  pos_r;
  logic [TIME_W-1:0] seen_r;
  ppt_tok_t          tok_r;
  ppt_tok_t          tok_nxt;

  logic [TIME_W:0] diff;
  logic            in_window;
  logic            online;
  logic            wr_hit;

  assign wr_hit = wr.en && (wr.idx == MY_IDX);

  // age of this entry, clamped at zero when time went backwards
  always_comb begin
    diff = {1'b0, item_now} - {1'b0, seen_r};
    if (diff[TIME_W]) begin
      in_window = (window != '0);
    end else begin
      in_window = (diff[TIME_W-1:WIN_W] == '0) && (diff[WIN_W-1:0] < window);
    end
    online = valid_r && in_window;
  end

  always_comb begin
    tok_nxt = tin;
    if (!tin.hit_found && valid_r && (addr_r == item_addr)) begin
      tok_nxt.hit_found  = 1'b1;
      tok_nxt.hit_idx    = MY_IDX;
      tok_nxt.hit_online = online;
    end
    if (!tin.free_found && !valid_r) begin
      tok_nxt.free_found = 1'b1;
      tok_nxt.vacant_idx = MY_IDX;
    end
    // first cell always seeds the oldest candidate
    if ((IDX == 0) || (seen_r < tin.oldest_time)) begin
      tok_nxt.oldest_idx    = MY_IDX;
      tok_nxt.oldest_time   = seen_r;
      tok_nxt.oldest_online = online;
    end
    tok_nxt.count = tin.count + CNT_W'(online);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr_hit) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      addr_r <= item_addr;
      pos_r  <= wr.pos;
      seen_r <= item_now;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tok_r <= tok_nxt;
    end
  end

  assign tout = tok_r;

endmodule
`default_nettype wire

// ===== hw/rtl/peer_presence_table_unit.sv =====
`default_nettype none
// a word is accepted only while idle; the search token then walks the cell chain
//   one entry per cycle, and the write state loads the result into the output
//   register once that register is free; no new word is accepted before the
//   result is loaded, so one search runs at a time
// reset (rst_n low, synchronous): clears every entry valid bit, sets the window
//   to 2000000 us, empties the output register; no clearing pass
`include "peer_presence_table_unit_defines.svh"
module peer_presence_table_unit #(
  parameter int TABLE_SLOTS = ppt_pkg::TABLE_SLOTS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         in_opcode,
  input  wire logic [ppt_pkg::ADDR_W-1:0]   in_reporter_address,
  input  wire logic [ppt_pkg::POS_W-1:0]    in_reported_position,
  input  wire logic [ppt_pkg::TIME_W-1:0]   in_now_us,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [ppt_pkg::SLOT_W-1:0]        out_slot_used,
  output logic                              out_address_matched,
  output logic [ppt_pkg::ONLINE_W-1:0]      out_online_count,
  input  wire logic                         cfg_wr_en,
  input  wire logic [ppt_pkg::WIN_W-1:0]    cfg_wr_data
);
  import ppt_pkg::*;

  localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam logic [IW-1:0] LAST_CELL = IW'(TABLE_SLOTS - 1);

  // sequencer state
  ppt_state_t state_r, state_nxt;
  logic [IW-1:0] cnt_r;

  // latched input word
  logic              op_r;
  logic [ADDR_W-1:0] addr_r;
  logic [POS_W-1:0]  pos_r;
  logic [TIME_W-1:0] now_r;

  logic [WIN_W-1:0] window_r;

  // output register
  logic                out_valid_r;
  logic [SLOT_W-1:0]   slot_r;
  logic                matched_r;
  logic [ONLINE_W-1:0] online_r;

  // control decoded from state
  logic    accept;
  logic    adv;
  logic    out_load;
  ppt_wr_t tbl_wr;

  // search token chain, entry 0 fed with an empty token
  ppt_tok_t chain_tok [TABLE_SLOTS+1];
  ppt_tok_t tail;

  // decision from the finished token
  logic [SLOT_IDX_W-1:0] pick_idx;
  logic                  pick_online;
  logic                  pick_match;
  logic [CNT_W-1:0]      new_count;
  logic [ONLINE_W-1:0]   sat_count;

  assign chain_tok[0] = '0;
  assign tail         = chain_tok[TABLE_SLOTS];

  for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_cell
    ppt_cell #(
      .IDX(g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .wr        (tbl_wr),
      .item_addr (addr_r),
      .item_now  (now_r),
      .window    (window_r),
      .tin       (chain_tok[g]),
      .tout      (chain_tok[g+1])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (cnt_r == LAST_CELL) state_nxt = S_WRITE;
      end
      S_WRITE: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    adv      = 1'b0;
    out_load = 1'b0;
    case (state_r)
      S_IDLE:  in_ready = 1'b1;
      S_SCAN:  adv      = 1'b1;
      S_WRITE: out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  assign accept = in_valid && in_ready;

  // hit first, then first free entry, else the oldest one
  always_comb begin
    pick_match = 1'b0;
    if (tail.hit_found) begin
      pick_idx    = tail.hit_idx;
      pick_online = tail.hit_online;
      pick_match  = 1'b1;
    end else if (tail.free_found) begin
      pick_idx    = tail.vacant_idx;
      pick_online = 1'b0;
    end else begin
      pick_idx    = tail.oldest_idx;
      pick_online = tail.oldest_online;
    end

    // the written entry has age zero, so it is online for any nonzero window
    if (op_r == OPC_REPORT) begin
      new_count = tail.count - CNT_W'(pick_online) + CNT_W'(window_r != '0);
    end else begin
      new_count = tail.count;
    end
    sat_count = (new_count > CNT_W'(ONLINE_MAX)) ? ONLINE_MAX : new_count[ONLINE_W-1:0];
  end

  assign tbl_wr.en  = out_load && (op_r == OPC_REPORT);
  assign tbl_wr.idx = pick_idx;
  assign tbl_wr.pos = pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      window_r <= WINDOW_RESET;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        cnt_r <= '0;
      end else if (adv) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cfg_wr_en) begin
        window_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_opcode;
      addr_r <= in_reporter_address;
      pos_r  <= in_reported_position;
      now_r  <= in_now_us;
    end
  end

  // output word holds until taken, next search runs meanwhile
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (op_r == OPC_REPORT) begin
        slot_r    <= pick_idx[SLOT_W-1:0];
        matched_r <= pick_match;
      end else begin
        slot_r    <= '0;
        matched_r <= 1'b0;
      end
      online_r <= sat_count;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_slot_used       = slot_r;
  assign out_address_matched = matched_r;
  assign out_online_count    = online_r;

  // a word enters the scan with the counter at the first cell
  `PPT_ASSERT_NEXT(a_accept_scan, accept, (state_r == S_SCAN) && (cnt_r == '0))
  // a table write always leaves a result in the output register
  `PPT_ASSERT_NEXT(a_write_result, tbl_wr.en, out_valid_r)
  // a query never reports a slot or a match
  `PPT_ASSERT_NEXT(a_query_clean, out_load && (op_r == OPC_QUERY), (slot_r == '0) && !matched_r)

endmodule
`default_nettype wire

// ===== tb/tb_peer_presence_table_unit.sv =====
`default_nettype none
module tb_peer_presence_table_unit;
  import ppt_pkg::*;

  localparam int SLOTS = TABLE_SLOTS_DEF;
  localparam int PHASE_WORDS = 170;
  // generous pad after the last result for the tail
  localparam int TAIL_CYCLES = 4 * (SLOTS + 2);

  localparam logic [WIN_W-1:0] WINDOW_MAX      = '1;
  localparam logic [WIN_W-1:0] WINDOW_SPEC_MAX = WIN_W'(60000000);

  // fixed station addresses for the directed words
  localparam logic [ADDR_W-1:0] STA_ALT_HI = 48'hAAAA_AAAA_AAAA;
  localparam logic [ADDR_W-1:0] STA_ALT_LO = 48'h5555_5555_5555;
  localparam logic [ADDR_W-1:0] STA_LSB    = 48'h0000_0000_0001;
  localparam logic [ADDR_W-1:0] STA_MSB    = 48'h8000_0000_0000;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic                matched;
    logic [ONLINE_W-1:0] count;
  } presence_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_opcode = OPC_QUERY;
  logic [ADDR_W-1:0]   in_reporter_address = '0;
  logic [POS_W-1:0]    in_reported_position = '0;
  logic [TIME_W-1:0]   in_now_us = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [SLOT_W-1:0]   out_slot_used;
  logic                out_address_matched;
  logic [ONLINE_W-1:0] out_online_count;
  logic                cfg_wr_en = 1'b0;
  logic [WIN_W-1:0]    cfg_wr_data = '0;

  // predicted table contents and window register
  logic [WIN_W-1:0]  window_us;
  logic              tbl_valid [SLOTS];
  logic [ADDR_W-1:0] tbl_addr  [SLOTS];
  logic [POS_W-1:0]  tbl_pos   [SLOTS];
  logic [TIME_W-1:0] tbl_seen  [SLOTS];

  // results still owed by the block, oldest first
  presence_result_t pending_presence[$];
  presence_result_t oldest_expected;

  int          error_count = 0;
  int          stall_left = 0;
  bit          in_gaps_on = 1'b1;
  bit          out_stalls_on = 1'b1;
  logic [TIME_W-1:0] sim_now_us = '0;

  peer_presence_table_unit u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_opcode            (in_opcode),
    .in_reporter_address  (in_reporter_address),
    .in_reported_position (in_reported_position),
    .in_now_us            (in_now_us),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_slot_used        (out_slot_used),
    .out_address_matched  (out_address_matched),
    .out_online_count     (out_online_count),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2000000;
    $display("** peer_presence_table_unit: FAILED **");
    $finish;
  end

  function automatic logic [ADDR_W-1:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // mostly back to back, some short gaps, now and then a long one
  function automatic int pick_gap(input bit enabled);
    int roll;
    if (!enabled) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // table update and online count for one accepted word
  function automatic presence_result_t predict_presence(input logic op,
                                                        input logic [ADDR_W-1:0] addr,
                                                        input logic [POS_W-1:0] pos,
                                                        input logic [TIME_W-1:0] now);
    presence_result_t res;
    int i;
    int hit_idx;
    int vacant_idx;
    int oldest_idx;
    int sel;
    int unsigned online;
    logic [TIME_W-1:0] age;
    res = '0;
    hit_idx = -1;
    vacant_idx = -1;
    oldest_idx = 0;
    online = 0;
    if (op == OPC_REPORT) begin
      for (i = 0; i < SLOTS; i++) begin
        if (tbl_valid[i] && tbl_addr[i] == addr) begin
          hit_idx = i;
          break;
        end
        if (!tbl_valid[i] && vacant_idx < 0) vacant_idx = i;
        // strict compare keeps the lowest index on a tie
        if (tbl_seen[i] < tbl_seen[oldest_idx]) oldest_idx = i;
      end
      if (hit_idx >= 0) begin
        sel = hit_idx;
        res.matched = 1'b1;
      end else if (vacant_idx >= 0) begin
        sel = vacant_idx;
      end else begin
        sel = oldest_idx;
      end
      tbl_valid[sel] = 1'b1;
      tbl_addr[sel]  = addr;
      tbl_pos[sel]   = pos;
      tbl_seen[sel]  = now;
      res.slot = SLOT_W'(sel);
    end
    for (i = 0; i < SLOTS; i++) begin
      if (tbl_valid[i]) begin
        // clock running backwards counts as zero age
        age = (now >= tbl_seen[i]) ? now - tbl_seen[i] : '0;
        if (age < TIME_W'(window_us)) online++;
      end
    end
    res.count = (online > ONLINE_MAX) ? ONLINE_MAX : ONLINE_W'(online);
    return res;
  endfunction

  // one input word: optional gap, hold until taken, then book the result
  task automatic send_word(input logic op, input logic [ADDR_W-1:0] addr,
                           input logic [POS_W-1:0] pos, input logic [TIME_W-1:0] now);
    int gap;
    gap = pick_gap(in_gaps_on);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid             <= 1'b1;
    in_opcode            <= op;
    in_reporter_address  <= addr;
    in_reported_position <= pos;
    in_now_us            <= now;
    do @(posedge clk); while (!in_ready);
    pending_presence.push_back(predict_presence(op, addr, pos, now));
  endtask

  // stop sending and let every owed result come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_presence.size() != 0) @(posedge clk);
  endtask

  // window write only with the block idle
  task automatic set_window(input logic [WIN_W-1:0] value);
    wait_for_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    window_us = value;
  endtask

  // empty-table query, then fill every entry with extreme fields
  task automatic test_query_and_fill();
    send_word(OPC_QUERY,  '1,         8'hFF, 48'd0);
    send_word(OPC_REPORT, '0,         8'h00, 48'd0);
    send_word(OPC_REPORT, '1,         8'hFF, 48'd0);
    send_word(OPC_REPORT, STA_ALT_HI, 8'h5A, 48'd10);
    send_word(OPC_REPORT, STA_ALT_LO, 8'hA5, 48'd10);
  endtask

  // full table: tie on the oldest, refresh, stale table, clock going back
  task automatic test_eviction_and_time();
    send_word(OPC_REPORT, STA_LSB, 8'h01, 48'd10);
    send_word(OPC_REPORT, '0,      8'h02, 48'd20);
    send_word(OPC_REPORT, STA_LSB, 8'h03, 48'd30);
    send_word(OPC_QUERY,  '0,      8'h00, '1);
    send_word(OPC_REPORT, STA_MSB, 8'h80, '1);
    send_word(OPC_QUERY,  rand48(), 8'h00, 48'd5);
    // refresh at an earlier time so no entry stays pinned at the top
    send_word(OPC_REPORT, STA_MSB, 8'h7F, 48'd40);
  endtask

  // zero window, one microsecond, widest 26-bit value, top of the range
  task automatic test_window_extremes();
    set_window('0);
    send_word(OPC_REPORT, STA_LSB, 8'h11, 48'd100);
    send_word(OPC_QUERY,  STA_LSB, 8'h00, 48'd100);
    set_window(WIN_W'(1));
    send_word(OPC_REPORT, STA_LSB, 8'h22, 48'd200);
    send_word(OPC_QUERY,  STA_LSB, 8'h00, 48'd200);
    send_word(OPC_QUERY,  STA_LSB, 8'h00, 48'd201);
    set_window(WINDOW_MAX);
    send_word(OPC_QUERY, '0, 8'h00, 48'd200 + TIME_W'(WINDOW_MAX) - 48'd1);
    send_word(OPC_QUERY, '0, 8'h00, 48'd200 + TIME_W'(WINDOW_MAX));
    set_window(WINDOW_SPEC_MAX);
    send_word(OPC_REPORT, STA_ALT_HI, 8'h33, 48'd300);
    sim_now_us = 48'd300;
  endtask

  // reports from a small station pool so hits and evictions dominate,
  // with strays, queries, ties, aging past the window and clock steps back
  task automatic test_random_presence(input int words, input logic [WIN_W-1:0] win,
                                      input bit idling, input bit allow_wrap);
    logic [ADDR_W-1:0] pool [6];
    logic [ADDR_W-1:0] addr;
    logic              op;
    int unsigned       span;
    int unsigned       step;
    int                roll;
    int                n;
    set_window(win);
    in_gaps_on    = idling;
    out_stalls_on = idling;
    foreach (pool[k]) pool[k] = rand48();
    span = (win < 2) ? 1 : win / 2;
    for (n = 0; n < words; n++) begin
      // sender holds off once per phase until the block is drained
      if (n == words / 2) wait_for_results();
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        step = 0;
      end else if (roll < 70) begin
        sim_now_us += $urandom_range(1, span);
      end else if (roll < 92) begin
        sim_now_us += $urandom_range(span, 3 * span);
      end else if (roll < 97) begin
        step = $urandom_range(1, span);
        if (sim_now_us > step) sim_now_us -= step;
      end else if (allow_wrap && roll == 99) begin
        sim_now_us = '1 - TIME_W'($urandom_range(0, span));
      end else begin
        sim_now_us += $urandom;
      end
      op = ($urandom_range(0, 99) < 80) ? OPC_REPORT : OPC_QUERY;
      addr = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, 5)] : rand48();
      send_word(op, addr, POS_W'($urandom), sim_now_us);
    end
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
  endtask

  // result side: check each taken word, then pick the next ready level
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_presence.size() == 0) begin
        $display("%0t: extra result word: expected none, actual slot %0d matched %0d count %0d",
                 $time, out_slot_used, out_address_matched, out_online_count);
        error_count++;
      end else begin
        oldest_expected = pending_presence.pop_front();
        if (out_slot_used !== oldest_expected.slot) begin
          $display("%0t: slot_used mismatch: expected %0d actual %0d",
                   $time, oldest_expected.slot, out_slot_used);
          error_count++;
        end
        if (out_address_matched !== oldest_expected.matched) begin
          $display("%0t: address_matched mismatch: expected %0d actual %0d",
                   $time, oldest_expected.matched, out_address_matched);
          error_count++;
        end
        if (out_online_count !== oldest_expected.count) begin
          $display("%0t: online_count mismatch: expected %0d actual %0d",
                   $time, oldest_expected.count, out_online_count);
          error_count++;
        end
      end
    end
    // stall length drawn like the sender gaps
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      stall_left = pick_gap(out_stalls_on);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    // predicted state matches the block after reset
    window_us = WINDOW_RESET;
    foreach (tbl_valid[k]) begin
      tbl_valid[k] = 1'b0;
      tbl_addr[k]  = '0;
      tbl_pos[k]   = '0;
      tbl_seen[k]  = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_query_and_fill();
    test_eviction_and_time();
    test_window_extremes();
    test_random_presence(PHASE_WORDS, WINDOW_RESET, 1'b1, 1'b0);
    test_random_presence(PHASE_WORDS, WIN_W'($urandom_range(1, 60000000)), 1'b1, 1'b0);
    // tiny window and no idling on either side
    test_random_presence(PHASE_WORDS, WIN_W'($urandom_range(1, 40)), 1'b0, 1'b0);
    test_random_presence(PHASE_WORDS, WINDOW_MAX, 1'b1, 1'b0);
    test_random_presence(PHASE_WORDS, WIN_W'($urandom_range(1000, 5000000)), 1'b1, 1'b1);

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_presence.size() == 0) begin
      $display("** peer_presence_table_unit: PASSED **");
    end else begin
      $display("** peer_presence_table_unit: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/ppt_pkg.sv
hw/rtl/ppt_cell.sv
hw/rtl/peer_presence_table_unit.sv
tb/tb_peer_presence_table_unit.sv
